@@ rtl/core/ltc_pkg.sv @@
package ltc_pkg;

   // token kinds on the result channel
   localparam logic [3:0] KIND_DELIM = 4'd0;
   localparam logic [3:0] KIND_IDENT = 4'd1;
   localparam logic [3:0] KIND_INT   = 4'd2;
   localparam logic [3:0] KIND_REAL  = 4'd3;
   localparam logic [3:0] KIND_LOGIC = 4'd4;
   localparam logic [3:0] KIND_REL   = 4'd5;
   localparam logic [3:0] KIND_ASSIGN = 4'd6;
   localparam logic [3:0] KIND_ARITH = 4'd7;
   localparam logic [3:0] KIND_ERROR = 4'd8;

   // queue between front and back, in result bundles
   localparam int QPTR_W      = 2;
   localparam int QUEUE_DEPTH = 1 << QPTR_W;
   localparam int QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] bad_char;
      logic       last_of_run;
   } rsp_type;

   // all results caused by one character
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } bundle_type;

endpackage

@@ rtl/core/lexical_token_classifier.sv @@
// Lexical token classifier. Feed one character beat per clock on req_ with
// line_end set on the last character of a line; each finished token leaves on
// rsp_ as its kind (delimiter run, identifier, integer, real, logical,
// relational, assignment, arithmetic, or error with the offending byte), and
// last_of_run marks the final result of the character that caused it. The
// front scanner takes a character every cycle as long as its four-entry result
// queue has room, whatever the output side does; characters that close no
// token use no queue room. The back drains the queue one result per cycle while
// rsp_stall is low, so a character that closes two tokens at once (a token
// ended by a one-character token on line end) leaves its queue entry only
// after both of its results have been loaded. After an error the rest of the
// line is dropped, and bytes that cannot start a token are dropped silently.
module lexical_token_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ltc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ltc_pkg::rsp_type rsp_data
);
   import ltc_pkg::*;

   // front to queue
   logic       q_push, q_full;
   bundle_type q_data;

   // queue to back
   logic       head_valid, pop;
   bundle_type head_data;

   // scan characters, track the token in progress, push closed tokens
   ltc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   // hold result bundles so the scanner waits on a stalled output only once the queue is full
   ltc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // split bundles into single result beats behind an output register
   ltc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/core/ltc_front.sv @@
module ltc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ltc_pkg::req_type    req_data,
   input  logic                q_full,
   output logic                q_push,
   output ltc_pkg::bundle_type q_data
);
   import ltc_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_DELIM, PH_IDENT, PH_INT, PH_REAL, PH_BANG,
      PH_RELTWO, PH_EQ, PH_GT, PH_LT, PH_ARITH
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      skip_ff, skip_in;

   logic [7:0] c;
   logic       accept, cont, err, emit_a, emit_b, kv_a, kv_b;
   logic [3:0] kind_a, kind_b;
   phase_type  nxt, after;

   function automatic logic is_letter(input logic [7:0] x);
      return (x >= 8'h61 && x <= 8'h7a) || (x >= 8'h41 && x <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] x);
      return x >= 8'h30 && x <= 8'h39;
   endfunction

   function automatic logic is_delim(input logic [7:0] x);
      return x == 8'h20 || x == 8'h09 || x == 8'h0a;
   endfunction

   function automatic logic is_rel(input logic [7:0] x);
      return x == 8'h3d || x == 8'h21 || x == 8'h3e || x == 8'h3c;
   endfunction

   function automatic logic is_arith(input logic [7:0] x);
      return x == 8'h2b || x == 8'h2d || x == 8'h2a || x == 8'h2f;
   endfunction

   // kind of a closed token; valid low for idle
   function automatic logic [4:0] phase_kind(input phase_type p);
      logic [4:0] r;
      case (p)
         PH_DELIM:  r = {1'b1, KIND_DELIM};
         PH_IDENT:  r = {1'b1, KIND_IDENT};
         PH_INT:    r = {1'b1, KIND_INT};
         PH_REAL:   r = {1'b1, KIND_REAL};
         PH_BANG:   r = {1'b1, KIND_LOGIC};
         PH_RELTWO: r = {1'b1, KIND_REL};
         PH_EQ:     r = {1'b1, KIND_ASSIGN};
         PH_GT:     r = {1'b1, KIND_REL};
         PH_LT:     r = {1'b1, KIND_REL};
         PH_ARITH:  r = {1'b1, KIND_ARITH};
         default:   r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic phase_type start_phase(input logic [7:0] x);
      phase_type r;
      if (is_delim(x)) r = PH_DELIM;
      else if (is_letter(x) || x == 8'h5f) r = PH_IDENT;
      else if (is_digit(x)) r = PH_INT;
      else if (x == 8'h21) r = PH_BANG;
      else if (x == 8'h3d) r = PH_EQ;
      else if (x == 8'h3e) r = PH_GT;
      else if (x == 8'h3c) r = PH_LT;
      else if (is_arith(x)) r = PH_ARITH;
      else r = PH_IDLE;
      return r;
   endfunction

   assign c         = req_data.ch;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      cont = 1'b0;
      err  = 1'b0;
      nxt  = phase_ff;
      case (phase_ff)
         PH_DELIM: cont = is_delim(c);
         PH_IDENT: cont = is_letter(c) || is_digit(c) || c == 8'h5f;
         PH_INT: begin
            if (is_digit(c)) begin
               cont = 1'b1;
            end else if (c == 8'h2e) begin
               cont = 1'b1;
               nxt  = PH_REAL;
            end
         end
         PH_REAL: cont = is_digit(c);
         PH_BANG, PH_EQ, PH_GT, PH_LT: begin
            if (c == 8'h3d) begin
               cont = 1'b1;
               nxt  = PH_RELTWO;
            end
         end
         PH_RELTWO: err = is_rel(c);
         PH_ARITH:  err = is_arith(c);
         default:   nxt = PH_IDLE;
      endcase
   end

   assign {kv_a, kind_a} = phase_kind(phase_ff);
   assign after          = cont ? nxt : start_phase(c);
   assign {kv_b, kind_b} = phase_kind(after);
   assign emit_a         = !skip_ff && !err && !cont && kv_a;
   assign emit_b         = !skip_ff && !err && req_data.line_end && kv_b;

   always_comb begin
      q_data.two                = emit_a && emit_b;
      q_data.first.bad_char     = 8'd0;
      q_data.first.last_of_run  = !(emit_a && emit_b);
      q_data.second.token_kind  = kind_b;
      q_data.second.bad_char    = 8'd0;
      q_data.second.last_of_run = 1'b1;
      if (err) begin
         q_data.first.token_kind = KIND_ERROR;
         q_data.first.bad_char   = c;
      end else if (emit_a) begin
         q_data.first.token_kind = kind_a;
      end else begin
         q_data.first.token_kind = kind_b;
      end
   end

   assign q_push = accept && !skip_ff && (err || emit_a || emit_b);

   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      if (accept) begin
         if (skip_ff) begin
            if (req_data.line_end) begin
               skip_in  = 1'b0;
               phase_in = PH_IDLE;
            end
         end else if (err) begin
            phase_in = PH_IDLE;
            skip_in  = !req_data.line_end;
         end else if (req_data.line_end) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

@@ rtl/core/ltc_queue.sv @@
module ltc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ltc_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ltc_pkg::bundle_type head_data
);
   import ltc_pkg::*;

   bundle_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_data  = slot_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/ltc_back.sv @@
module ltc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ltc_pkg::bundle_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ltc_pkg::rsp_type    rsp_data
);
   import ltc_pkg::*;

   logic    valid_ff, valid_in;
   logic    sel_ff, sel_in;
   rsp_type rsp_ff;
   logic    load;

   assign load      = head_valid && (!valid_ff || !rsp_stall);
   assign pop       = load && (sel_ff || !head_data.two);
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = !sel_ff && head_data.two;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= sel_ff ? head_data.second : head_data.first;
      end
   end

endmodule
